[rtl/core/gheg_pkg.sv]
// Shared constants for the gaussian high-emphasis gain block.
// No dependencies; used by the top level and the exponential table.
`default_nettype none

package gheg_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] C_REG_WIDTH  = 3'd0;
    localparam logic [2:0] C_REG_HEIGHT = 3'd1;
    localparam logic [2:0] C_REG_CUTOFF = 3'd2;
    localparam logic [2:0] C_REG_HIGH   = 3'd3;
    localparam logic [2:0] C_REG_LOW    = 3'd4;

    localparam int C_SIZE_W   = 11;   // width_in_use / height_in_use
    localparam int C_COORD_W  = 10;   // col / row index and folded distance
    localparam int C_SQ_W     = 20;   // one squared distance
    localparam int C_D2_W     = 21;   // squared radius
    localparam int C_DIV_W    = 23;   // 8 * D0^2
    localparam int C_GAIN_W   = 16;   // unsigned Q8.8
    localparam int C_EXP_W    = 17;   // unsigned Q0.16, one is 2^16
    localparam int C_MAX_SIZE = 1024;

    localparam logic [C_EXP_W-1:0] C_EXP_ONE = 17'h10000;

    // reset values
    localparam logic [C_SIZE_W-1:0]  C_WIDTH_RST  = 11'd256;
    localparam logic [C_SIZE_W-1:0]  C_HEIGHT_RST = 11'd256;
    localparam logic [C_COORD_W-1:0] C_CUTOFF_RST = 10'd10;
    localparam logic [C_GAIN_W-1:0]  C_HIGH_RST   = 16'd1280;
    localparam logic [C_GAIN_W-1:0]  C_LOW_RST    = 16'd128;
    localparam logic [C_DIV_W-1:0]   C_DIV_RST    = 23'd800;

endpackage

`default_nettype wire

[rtl/core/gaussian_high_emphasis_gain.sv]
// Gaussian high-emphasis gain: each request carries one complex Q16.16 bin with its
// column and row, and leaves scaled by H = k1*(1-E) + k2*E, E = exp(-D^2/D0^2), with
// the product rounded half up and saturated to 32 bits. One bin per cycle is taken while
// the pipeline is not stalled; the table index divider resolves one quotient bit per stage.
// Stalls hold each valid item that has no empty stage ahead of it; empty stages keep
// filling. Depends on gheg_pkg and gheg_exp_rom.
`default_nettype none

module gaussian_high_emphasis_gain #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [2:0]                           i_cfg_index,
    input  wire logic [15:0]                          i_cfg_data,
    // bins in
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [31:0]                   i_bin_real,
    input  wire logic signed [31:0]                   i_bin_imag,
    input  wire logic [gheg_pkg::C_COORD_W-1:0]       i_col_index,
    input  wire logic [gheg_pkg::C_COORD_W-1:0]       i_row_index,
    // scaled bins out
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [31:0]                        o_scaled_real,
    output logic signed [31:0]                        o_scaled_imag,
    output logic                                      o_saturated
);

    localparam int QB     = $clog2(EXP_TABLE_DEPTH);
    localparam int NW     = gheg_pkg::C_D2_W + QB;
    localparam int S_FOLD = 1;
    localparam int S_SQ   = 2;
    localparam int S_SUM  = 3;
    localparam int S_ROM  = S_SUM + QB + 1;
    localparam int S_GP   = S_ROM + 1;
    localparam int S_GAIN = S_GP + 1;
    localparam int S_PROD = S_GAIN + 1;
    localparam int NS     = S_PROD + 1;

    localparam int CW = gheg_pkg::C_COORD_W;
    localparam int DV = gheg_pkg::C_DIV_W;
    localparam int EW = gheg_pkg::C_EXP_W;
    localparam int GW = gheg_pkg::C_GAIN_W;

    // ---------------------------------------------------------------- config
    logic [gheg_pkg::C_SIZE_W-1:0] r_width;
    logic [gheg_pkg::C_SIZE_W-1:0] r_height;
    logic [CW-1:0]                 r_cutoff;
    logic [GW-1:0]                 r_high_gain;
    logic [GW-1:0]                 r_low_gain;
    logic [DV-1:0]                 r_div;
    logic [DV-1:0]                 n_div;
    logic [CW-1:0]                 w_d0;
    logic [gheg_pkg::C_SQ_W-1:0]   w_d0_sq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= gheg_pkg::C_WIDTH_RST;
            r_height    <= gheg_pkg::C_HEIGHT_RST;
            r_cutoff    <= gheg_pkg::C_CUTOFF_RST;
            r_high_gain <= gheg_pkg::C_HIGH_RST;
            r_low_gain  <= gheg_pkg::C_LOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gheg_pkg::C_REG_WIDTH:  r_width     <= i_cfg_data[10:0];
                gheg_pkg::C_REG_HEIGHT: r_height    <= i_cfg_data[10:0];
                gheg_pkg::C_REG_CUTOFF: r_cutoff    <= i_cfg_data[9:0];
                gheg_pkg::C_REG_HIGH:   r_high_gain <= i_cfg_data;
                gheg_pkg::C_REG_LOW:    r_low_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divisor 8*D0^2, zero cutoff acts as one
    assign w_d0    = (r_cutoff == '0) ? CW'(1) : r_cutoff;
    assign w_d0_sq = {10'd0, w_d0} * {10'd0, w_d0};
    assign n_div   = {w_d0_sq, 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= gheg_pkg::C_DIV_RST;
        end else begin
            r_div <= n_div;
        end
    end

    // ------------------------------------------------------- pipeline control
    logic [NS:1] r_vld;
    logic [NS:1] w_rdy;

    assign w_rdy[NS] = !r_vld[NS] || !i_stall;
    for (genvar k = 1; k < NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_rdy[1];
    assign o_valid = r_vld[NS];

    // bin parts ride along until the product stage
    logic signed [31:0] r_re [1:S_GAIN];
    logic signed [31:0] r_im [1:S_GAIN];

    for (genvar k = 2; k <= S_GAIN; k++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_re[k] <= r_re[k-1];
                r_im[k] <= r_im[k-1];
            end
        end
    end

    // ------------------------------------------------------------- fold
    function automatic logic [CW-1:0] fold(logic [CW-1:0] idx,
                                           logic [gheg_pkg::C_SIZE_W-1:0] size);
        logic [gheg_pkg::C_SIZE_W-1:0] sz;
        logic [gheg_pkg::C_SIZE_W-1:0] ix;
        sz = (size > gheg_pkg::C_SIZE_W'(gheg_pkg::C_MAX_SIZE)) ?
             gheg_pkg::C_SIZE_W'(gheg_pkg::C_MAX_SIZE) : size;
        ix = {1'b0, idx};
        if (ix < (sz >> 1)) begin
            fold = idx;
        end else if (ix >= sz) begin
            fold = CW'(ix - sz);
        end else begin
            fold = CW'(sz - ix);
        end
    endfunction

    logic [CW-1:0] r_dx;
    logic [CW-1:0] r_dy;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_FOLD]) begin
            r_re[S_FOLD] <= i_bin_real;
            r_im[S_FOLD] <= i_bin_imag;
            r_dx         <= fold(i_col_index, r_width);
            r_dy         <= fold(i_row_index, r_height);
        end
    end

    // ------------------------------------------------------------- squares
    logic [gheg_pkg::C_SQ_W-1:0] r_dx2;
    logic [gheg_pkg::C_SQ_W-1:0] r_dy2;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_SQ]) begin
            r_dx2 <= {10'd0, r_dx} * {10'd0, r_dx};
            r_dy2 <= {10'd0, r_dy} * {10'd0, r_dy};
        end
    end

    // ------------------------------------------------- radius and divider
    // idx = floor(D2*DEPTH / (8*D0^2)); only needed when D2 < 8*D0^2
    logic [DV-1:0] r_rem [S_SUM:S_ROM-1];
    logic [QB-1:0] r_quo [S_SUM:S_ROM-1];
    logic [QB-1:0] r_nlo [S_SUM:S_ROM-1];
    logic          r_hit [S_SUM:S_ROM-1];

    logic [gheg_pkg::C_D2_W-1:0] w_d2;
    logic [NW-1:0]               w_num;

    assign w_d2  = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_num = NW'(w_d2) * NW'(EXP_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_SUM]) begin
            r_rem[S_SUM] <= DV'(w_num >> QB);
            r_nlo[S_SUM] <= w_num[QB-1:0];
            r_quo[S_SUM] <= '0;
            r_hit[S_SUM] <= {2'b00, w_d2} < r_div;
        end
    end

    for (genvar s = S_SUM + 1; s < S_ROM; s++) begin : g_div
        logic [DV:0] w_trial;
        logic        w_ge;

        assign w_trial = {r_rem[s-1], r_nlo[s-1][QB-1]};
        assign w_ge    = w_trial >= {1'b0, r_div};

        always_ff @(posedge i_clk) begin
            if (w_rdy[s]) begin
                r_rem[s] <= w_ge ? DV'(w_trial - {1'b0, r_div}) : w_trial[DV-1:0];
                r_quo[s] <= {r_quo[s-1][QB-2:0], w_ge};
                r_nlo[s] <= r_nlo[s-1] << 1;
                r_hit[s] <= r_hit[s-1];
            end
        end
    end

    // ------------------------------------------------------------ table
    logic [EW-1:0] w_exp;

    gheg_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_rom (
        .i_clk (i_clk),
        .i_en  (w_rdy[S_ROM]),
        .i_hit (r_hit[S_ROM-1]),
        .i_idx (r_quo[S_ROM-1]),
        .o_exp (w_exp)
    );

    // ------------------------------------------------------------- gain
    logic [32:0]   r_ga;
    logic [32:0]   r_gb;
    logic [EW-1:0] w_einv;

    assign w_einv = gheg_pkg::C_EXP_ONE - w_exp;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_GP]) begin
            r_ga <= {17'd0, r_high_gain} * {16'd0, w_einv};
            r_gb <= {17'd0, r_low_gain} * {16'd0, w_exp};
        end
    end

    logic [33:0]   w_hq;
    logic [GW-1:0] r_gain;

    // sum stays below 2^32, so the Q8.8 gain fits 16 bits
    assign w_hq = {1'b0, r_ga} + {1'b0, r_gb} + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_GAIN]) begin
            r_gain <= w_hq[31:16];
        end
    end

    // ---------------------------------------------------------- products
    logic signed [16:0] w_g;
    logic signed [48:0] w_pr;
    logic signed [48:0] w_pi;
    logic signed [47:0] r_pr;
    logic signed [47:0] r_pi;

    assign w_g  = signed'({1'b0, r_gain});
    assign w_pr = r_re[S_GAIN] * w_g;
    assign w_pi = r_im[S_GAIN] * w_g;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_PROD]) begin
            r_pr <= w_pr[47:0];
            r_pi <= w_pi[47:0];
        end
    end

    // -------------------------------------------------- round and saturate
    // returns {clipped, value}
    function automatic logic [32:0] round_sat(logic signed [47:0] p);
        logic signed [47:0] s;
        logic signed [39:0] q;
        s = p + 48'sd128;
        q = 40'(s >>> 8);
        if (!q[39] && q[38:31] != '0) begin
            round_sat = {1'b1, 32'h7FFF_FFFF};
        end else if (q[39] && q[38:31] != '1) begin
            round_sat = {1'b1, 32'h8000_0000};
        end else begin
            round_sat = {1'b0, q[31:0]};
        end
    endfunction

    logic [32:0] w_or;
    logic [32:0] w_oi;

    assign w_or = round_sat(r_pr);
    assign w_oi = round_sat(r_pi);

    logic signed [31:0] r_out_re;
    logic signed [31:0] r_out_im;
    logic               r_out_sat;

    always_ff @(posedge i_clk) begin
        if (w_rdy[NS]) begin
            r_out_re  <= w_or[31:0];
            r_out_im  <= w_oi[31:0];
            r_out_sat <= w_or[32] | w_oi[32];
        end
    end

    assign o_scaled_real = r_out_re;
    assign o_scaled_imag = r_out_im;
    assign o_saturated   = r_out_sat;

endmodule

`default_nettype wire

[rtl/core/gheg_exp_rom.sv]
// Exponential falloff table exp(-8*i/DEPTH) in unsigned Q0.16, registered read.
// The table is built at elaboration; the entry width comes from gheg_pkg.
`default_nettype none

module gheg_exp_rom #(
    parameter int DEPTH = 256,
    localparam int IW = $clog2(DEPTH)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic                         i_hit,
    input  wire logic [IW-1:0]                i_idx,
    output logic      [gheg_pkg::C_EXP_W-1:0] o_exp
);

    typedef logic [gheg_pkg::C_EXP_W-1:0] t_exp_tab [DEPTH];

    // series argument 8/DEPTH in Q32
    localparam logic [127:0] STEP = (128'd8 << 32) / DEPTH;

    // shift and subtract quotient, only evaluated while the table is built
    function automatic logic [127:0] long_div(logic [127:0] num, logic [127:0] den);
        logic [127:0] quo;
        logic [127:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 127; b >= 0; b--) begin
            rem = {rem[126:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // base = exp(-8/DEPTH) in Q32 from a truncated series, then repeated products
    function automatic t_exp_tab build_tab();
        logic [127:0] term;
        logic [127:0] base;
        logic [127:0] acc;
        t_exp_tab     tab;
        term = 128'd1 << 32;
        base = term;
        for (int n = 1; n <= 12; n++) begin
            term = long_div((term * STEP) >> 32, 128'(n));
            if ((n & 1) != 0) begin
                base = base - term;
            end else begin
                base = base + term;
            end
        end
        acc = 128'd1 << 32;
        for (int i = 0; i < DEPTH; i++) begin
            tab[i] = gheg_pkg::C_EXP_W'((acc + 128'd32768) >> 16);
            acc = (acc * base + (128'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_tab();

    logic [gheg_pkg::C_EXP_W-1:0] r_exp;

    // arguments of 8 or more give zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_exp <= i_hit ? EXP_TAB[i_idx] : '0;
        end
    end

    assign o_exp = r_exp;

endmodule

`default_nettype wire

[bench/gaussian_high_emphasis_gain_tb.sv]
// Self-checking bench for gaussian_high_emphasis_gain: directed corner bins, a long
// receiver hold-off, then random bins over several register settings.
// Depends on gheg_pkg and the gaussian_high_emphasis_gain RTL.
`default_nettype none

module gaussian_high_emphasis_gain_tb;

    localparam int EXP_DEPTH       = 256;
    localparam int LATENCY         = $clog2(EXP_DEPTH) + 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RAND_PHASES     = 5;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int IDLE_PERCENT    = 17;

    // first index past the register list; writes there must be ignored
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;

    localparam longint PART_MAX = 64'sh7FFF_FFFF;
    localparam longint PART_MIN = -PART_MAX - 1;

    typedef struct packed {
        logic signed [31:0] scaled_real;
        logic signed [31:0] scaled_imag;
        logic               saturated;
    } t_scaled_bin;

    logic                               i_clk;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_valid   = 1'b0;
    logic                               o_cfg_ready;
    logic [2:0]                         i_cfg_index   = '0;
    logic [15:0]                        i_cfg_data    = '0;
    logic                               i_valid       = 1'b0;
    logic                               o_stall;
    logic signed [31:0]                 i_bin_real    = '0;
    logic signed [31:0]                 i_bin_imag    = '0;
    logic [gheg_pkg::C_COORD_W-1:0]     i_col_index   = '0;
    logic [gheg_pkg::C_COORD_W-1:0]     i_row_index   = '0;
    logic                               o_valid;
    logic                               i_stall       = 1'b0;
    logic signed [31:0]                 o_scaled_real;
    logic signed [31:0]                 o_scaled_imag;
    logic                               o_saturated;

    // register copies, updated when the block accepts a write
    logic [gheg_pkg::C_SIZE_W-1:0]      shadow_width  = gheg_pkg::C_WIDTH_RST;
    logic [gheg_pkg::C_SIZE_W-1:0]      shadow_height = gheg_pkg::C_HEIGHT_RST;
    logic [gheg_pkg::C_COORD_W-1:0]     shadow_cutoff = gheg_pkg::C_CUTOFF_RST;
    logic [gheg_pkg::C_GAIN_W-1:0]      shadow_high   = gheg_pkg::C_HIGH_RST;
    logic [gheg_pkg::C_GAIN_W-1:0]      shadow_low    = gheg_pkg::C_LOW_RST;

    int unsigned                decay_q16 [EXP_DEPTH];
    t_scaled_bin                pending_bins [$];

    int  mismatches     = 0;
    int  bins_checked   = 0;
    int  clipped_seen   = 0;
    int  held_cycles    = 0;
    int  settings_used  = 1;
    int  cycle_count    = 0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;
    bit  quiet          = 1'b0;

    gaussian_high_emphasis_gain #(
        .EXP_TABLE_DEPTH(EXP_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_bin_real    (i_bin_real),
        .i_bin_imag    (i_bin_imag),
        .i_col_index   (i_col_index),
        .i_row_index   (i_row_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_scaled_real (o_scaled_real),
        .o_scaled_imag (o_scaled_imag),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // exp(-i*8/depth) in Q0.16, from a Q32 ratio raised step by step
    function automatic void build_decay_table();
        bit [63:0] rate_q32, term, ratio, acc;
        rate_q32 = (64'd8 << 32) / EXP_DEPTH;
        term     = 64'd1 << 32;
        ratio    = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * rate_q32) >> 32) / n;
            if (n % 2) ratio = ratio - term;
            else       ratio = ratio + term;
        end
        acc = 64'd1 << 32;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            decay_q16[i] = 32'((acc + 64'd32768) >> 16);
            acc = (acc * ratio + (64'd1 << 31)) >> 32;
        end
    endfunction

    function automatic longint unsigned wrap_distance(int unsigned coord, int unsigned size);
        if (size > gheg_pkg::C_MAX_SIZE) size = gheg_pkg::C_MAX_SIZE;
        if (coord < size / 2) return coord;
        return (coord >= size) ? coord - size : size - coord;
    endfunction

    // {clipped, value}: Q16.16 times Q8.8, rounded half up, clipped to 32 bits
    function automatic logic [32:0] apply_gain(logic signed [31:0] part, logic [15:0] gain);
        longint prod, q;
        prod = longint'(part) * longint'(gain);
        q    = (prod + 128) >>> 8;
        if (q > PART_MAX) return {1'b1, 32'h7FFF_FFFF};
        if (q < PART_MIN) return {1'b1, 32'h8000_0000};
        return {1'b0, q[31:0]};
    endfunction

    function automatic t_scaled_bin emphasize_bin(logic signed [31:0] re, logic signed [31:0] im,
                                                  logic [9:0] col, logic [9:0] row);
        t_scaled_bin       r;
        longint unsigned   dx, dy, d2, d0, idx, e, mix;
        logic [15:0]       gain;
        logic [32:0]       re_part, im_part;
        dx   = wrap_distance(col, shadow_width);
        dy   = wrap_distance(row, shadow_height);
        d2   = dx * dx + dy * dy;
        d0   = (shadow_cutoff == 0) ? 1 : shadow_cutoff;
        idx  = d2 * EXP_DEPTH / (8 * d0 * d0);
        e    = (idx < EXP_DEPTH) ? decay_q16[idx] : 0;
        mix  = shadow_high * (65536 - e) + shadow_low * e;
        gain = 16'((mix + 32768) >> 16);
        re_part = apply_gain(re, gain);
        im_part = apply_gain(im, gain);
        r.scaled_real = re_part[31:0];
        r.scaled_imag = im_part[31:0];
        r.saturated   = re_part[32] | im_part[32];
        return r;
    endfunction

    function automatic logic [31:0] rand_part();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (pick < 4) return $urandom;
        if (pick < 7) return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
        return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
    endfunction

    // favor coordinates close to zero frequency, wrapped or not, where the gain bends
    function automatic logic [9:0] rand_coord(logic [10:0] size);
        int eff, span, c;
        eff  = (size > gheg_pkg::C_MAX_SIZE) ? gheg_pkg::C_MAX_SIZE : size;
        span = 3 * ((shadow_cutoff == 0) ? 1 : shadow_cutoff) + 1;
        if (span > 1023) span = 1023;
        case ($urandom_range(0, 9))
            0, 1, 2: c = $urandom_range(0, span);
            3, 4, 5: c = eff - int'($urandom_range(0, span));
            6:       c = $urandom_range(0, 1023);
            default: c = (eff > 0) ? int'($urandom_range(0, eff - 1)) : 0;
        endcase
        if (c < 0)    c = 0;
        if (c > 1023) c = 1023;
        return c[9:0];
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gaussian_high_emphasis_gain_tb: errors");
            $finish;
        end
    end

    // receiver: random stalls unless quiet, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_scaled_bin want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gheg_pkg::C_REG_WIDTH:
                        shadow_width  = i_cfg_data[gheg_pkg::C_SIZE_W-1:0];
                    gheg_pkg::C_REG_HEIGHT:
                        shadow_height = i_cfg_data[gheg_pkg::C_SIZE_W-1:0];
                    gheg_pkg::C_REG_CUTOFF:
                        shadow_cutoff = i_cfg_data[gheg_pkg::C_COORD_W-1:0];
                    gheg_pkg::C_REG_HIGH:   shadow_high   = i_cfg_data;
                    gheg_pkg::C_REG_LOW:    shadow_low    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_stall) held_cycles++;
            if (i_valid && !o_stall)
                pending_bins.push_back(emphasize_bin(i_bin_real, i_bin_imag,
                                                     i_col_index, i_row_index));
            if (o_valid && !i_stall) begin
                if (pending_bins.size() == 0) begin
                    $error("scaled bin with no request outstanding");
                    mismatches++;
                end else begin
                    want = pending_bins.pop_front();
                    bins_checked++;
                    if (want.saturated) clipped_seen++;
                    if (o_scaled_real !== want.scaled_real) begin
                        $error("scaled_real: expected %0d, got %0d",
                               want.scaled_real, o_scaled_real);
                        mismatches++;
                    end
                    if (o_scaled_imag !== want.scaled_imag) begin
                        $error("scaled_imag: expected %0d, got %0d",
                               want.scaled_imag, o_scaled_imag);
                        mismatches++;
                    end
                    if (o_saturated !== want.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               want.saturated, o_saturated);
                        mismatches++;
                    end
                end
            end
        end
    end

    // valid stays up from one request to the next unless a gap is drawn
    task automatic send_bin(input logic [31:0] re, input logic [31:0] im,
                            input logic [9:0] col, input logic [9:0] row);
        if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_bin_real  <= re;
        i_bin_imag  <= im;
        i_col_index <= col;
        i_row_index <= row;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // only called with the block drained
    task automatic write_settings(input logic [15:0] width, input logic [15:0] height,
                                  input logic [15:0] cutoff, input logic [15:0] high,
                                  input logic [15:0] low);
        write_reg(gheg_pkg::C_REG_WIDTH, width);
        write_reg(gheg_pkg::C_REG_HEIGHT, height);
        write_reg(gheg_pkg::C_REG_CUTOFF, cutoff);
        write_reg(gheg_pkg::C_REG_HIGH, high);
        write_reg(gheg_pkg::C_REG_LOW, low);
        write_reg(REG_SPARE_FIRST + 3'($urandom_range(0, 2)), 16'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        send_bin(32'h0001_0000, 32'hFFFF_0000, 10'd0, 10'd0);      // gain is k2 at the origin
        send_bin(32'h0001_0000, 32'hFFFF_0000, 10'd128, 10'd128);  // far out, gain is k1
        send_bin(32'h0003_4567, 32'hFFF0_1234, 10'd5, 10'd3);
        send_bin(32'h0002_0000, 32'h0002_0000, 10'd255, 10'd1);    // wraps to distance 1
        send_bin(32'h0002_0000, 32'hFFFE_0000, 10'd128, 10'd0);    // exactly half the width
        send_bin(32'h0002_0000, 32'hFFFE_0000, 10'd127, 10'd20);
        send_bin(32'h1234_5678, 32'h8765_4321, 10'd1023, 10'd1023); // beyond the spectrum
        send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd100, 10'd100);  // clips both ways
        send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd0, 10'd0);
        send_bin(32'h0000_0001, 32'hFFFF_FFFF, 10'd0, 10'd0);      // rounding ties
        send_bin(32'h0000_0000, 32'h0000_0000, 10'd9, 10'd250);
        wait_drained();
    endtask

    task automatic test_corner_settings();
        // zero cutoff acts as one; k1 at maximum, k2 zero
        write_settings(16'd2, 16'd1024, 16'd0, 16'hFFFF, 16'd0);
        send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd0, 10'd0);
        send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd1, 10'd512);
        send_bin(32'h0000_0100, 32'hFFFF_FF00, 10'd1023, 10'd511);
        send_bin(32'h0000_0001, 32'hFFFF_FFFF, 10'd2, 10'd1);
        wait_drained();
        // width beyond the largest size, widest Gaussian
        write_settings(16'd2047, 16'd2, 16'd1023, 16'd0, 16'hFFFF);
        send_bin(32'h0000_8000, 32'hFFFF_8000, 10'd0, 10'd0);
        send_bin(32'h0080_0000, 32'hFF7F_FFFF, 10'd1023, 10'd1);
        send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd600, 10'd1023);
        send_bin(32'h5555_5555, 32'hAAAA_AAAA, 10'd512, 10'd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        hold_requests++;
        @(posedge i_clk);
        repeat (60) send_bin(rand_part(), rand_part(),
                             rand_coord(shadow_width), rand_coord(shadow_height));
        wait_drained();
        quiet = 1'b0;
    endtask

    task automatic test_random_settings();
        logic [15:0] w, h, c, hi, lo;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin
                    w = 16'd1024; h = 16'd1024; c = 16'd1023;
                    hi = 16'($urandom); lo = 16'($urandom);
                end
                1: begin
                    w = 16'd2; h = 16'd2; c = 16'd1; hi = 16'hFFFF; lo = 16'hFFFF;
                end
                default: begin
                    w  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(2, 1024));
                    h  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(2, 1024));
                    c  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1023))
                                                     : 16'($urandom_range(1, 40));
                    hi = 16'($urandom);
                    lo = 16'($urandom);
                end
            endcase
            write_settings(w, h, c, hi, lo);
            quiet = (phase == 2);
            repeat (ITEMS_PER_PHASE)
                send_bin(rand_part(), rand_part(),
                         rand_coord(shadow_width), rand_coord(shadow_height));
            wait_drained();
            quiet = 1'b0;
        end
    endtask

    initial begin
        build_decay_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_corner_settings();
        test_backpressure();
        test_random_settings();

        $display("checked %0d scaled bins (%0d clipped) across %0d register settings",
                 bins_checked, clipped_seen, settings_used);
        $display("input held back by the block for %0d cycles", held_cycles);
        if (mismatches == 0) begin
            $display("gaussian_high_emphasis_gain_tb: clean");
        end else begin
            $display("gaussian_high_emphasis_gain_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
